// ----- rtl/core/cidt_pkg.sv -----
// package for the can identifier change tracker
// shared widths, row and result structs, lane constants; no dependencies
package cidt_pkg;

    localparam int KEY_W          = 29;
    localparam int DLC_W          = 4;
    localparam int PAYLOAD_BYTES  = 8;
    localparam int DATA_W         = 64;
    localparam int TIME_W         = 64;
    localparam int COUNT_W        = 32;
    localparam int FLAGS_W        = 10;
    localparam int TABLE_ROWS_DEF = 64;

    // key compare lanes, one stored row per lane per cycle
    localparam int LANES  = 8;
    localparam int LANE_W = $clog2(LANES);

    // flag word layout: new mark, length changed, byte change mask
    localparam int FLAG_NEW_BIT  = 0;
    localparam int FLAG_LEN_BIT  = 1;
    localparam int FLAG_MASK_LSB = 2;

    typedef struct packed {
        logic [DLC_W-1:0]   length;
        logic [DATA_W-1:0]  bytes;
        logic [FLAGS_W-1:0] flags;
        logic [TIME_W-1:0]  last_us;
        logic [COUNT_W-1:0] count;
    } t_row;

    typedef struct packed {
        logic                     first_seen;
        logic                     length_changed;
        logic [PAYLOAD_BYTES-1:0] byte_change_mask;
        logic                     row_updated;
        logic [COUNT_W-1:0]       update_total;
        logic [TIME_W-1:0]        last_change_us;
        logic                     table_full;
    } t_result;

    localparam int ROW_DATA_W = $bits(t_row);

endpackage

// ----- rtl/core/cidt_if.sv -----
// frame and result channel interfaces for the identifier change tracker
// depends on cidt_pkg for the field widths
interface cidt_frame_if;
    logic                       valid;
    logic                       ready;
    logic [cidt_pkg::KEY_W-1:0]  can_id;
    logic [cidt_pkg::DLC_W-1:0]  length_code;
    logic [cidt_pkg::DATA_W-1:0] payload;
    logic [cidt_pkg::TIME_W-1:0] host_time_us;

    modport source (output valid, can_id, length_code, payload, host_time_us, input ready);
    modport sink   (input valid, can_id, length_code, payload, host_time_us, output ready);
endinterface

interface cidt_result_if;
    logic                                valid;
    logic                                ready;
    logic                                first_seen;
    logic                                length_changed;
    logic [cidt_pkg::PAYLOAD_BYTES-1:0]  byte_change_mask;
    logic                                row_updated;
    logic [cidt_pkg::COUNT_W-1:0]        update_total;
    logic [cidt_pkg::TIME_W-1:0]         last_change_us;
    logic                                table_full;

    modport source (output valid, first_seen, length_changed, byte_change_mask, row_updated,
                    update_total, last_change_us, table_full, input ready);
    modport sink   (input valid, first_seen, length_changed, byte_change_mask, row_updated,
                    update_total, last_change_us, table_full, output ready);
endinterface

// ----- rtl/core/cidt_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies
module cidt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                     i_wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                     o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/cidt_lane.sv -----
// one key compare lane: holds the keys of rows lane, lane+LANES, ... in a ram
// and matches the row read out against the frame key; depends on cidt_pkg, cidt_ram
module cidt_lane #(
    parameter int GROUPS   = 8,
    parameter int GRP_W    = 3,
    parameter int FILL_W   = 7,
    parameter int LANE_IDX = 0
) (
    input  logic                         i_clk,
    input  logic                         i_wr_en,
    input  logic [GRP_W-1:0]             i_wr_grp,
    input  logic [cidt_pkg::KEY_W-1:0]   i_wr_key,
    input  logic [GRP_W-1:0]             i_rd_grp,
    input  logic [GRP_W-1:0]             i_cmp_grp,
    input  logic [cidt_pkg::KEY_W-1:0]   i_key,
    input  logic [FILL_W-1:0]            i_fill,
    output logic                         o_hit
);

    localparam int ROW_W = GRP_W + cidt_pkg::LANE_W;
    localparam int CMP_W = ROW_W + FILL_W;

    logic [cidt_pkg::KEY_W-1:0] rd_key;
    logic [ROW_W-1:0]           row_idx;

    cidt_ram #(
        .WIDTH (cidt_pkg::KEY_W),
        .DEPTH (GROUPS)
    ) u_key_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr_en),
        .i_wr_addr (i_wr_grp),
        .i_wr_data (i_wr_key),
        .i_rd_addr (i_rd_grp),
        .o_rd_data (rd_key)
    );

    assign row_idx = {i_cmp_grp, cidt_pkg::LANE_W'(LANE_IDX)};

    // rows at or above the fill count were never inserted
    assign o_hit = (CMP_W'(row_idx) < CMP_W'(i_fill)) && (rd_key == i_key);

endmodule

// ----- rtl/core/cidt_merge.sv -----
// merges the lane hits of one row group into the lowest matching lane
// depends on cidt_pkg
module cidt_merge (
    input  logic [cidt_pkg::LANES-1:0]  i_hits,
    output logic                        o_hit,
    output logic [cidt_pkg::LANE_W-1:0] o_lane
);

    always_comb begin
        o_lane = '0;
        for (int l = cidt_pkg::LANES - 1; l >= 0; l--) begin
            if (i_hits[l]) begin
                o_lane = cidt_pkg::LANE_W'(l);
            end
        end
    end

    assign o_hit = |i_hits;

endmodule

// ----- rtl/core/cidt_row_update.sv -----
// computes the new row contents and the result for an insert or a hit
// depends on cidt_pkg for the row and result structs
module cidt_row_update (
    input  logic                          i_insert,
    input  cidt_pkg::t_row                i_row,
    input  logic [cidt_pkg::DLC_W-1:0]    i_dlc,
    input  logic [cidt_pkg::DATA_W-1:0]   i_data,
    input  logic [cidt_pkg::TIME_W-1:0]   i_rel,
    output cidt_pkg::t_row                o_row,
    output cidt_pkg::t_result             o_result
);

    logic [cidt_pkg::PAYLOAD_BYTES-1:0] in_len;
    logic [cidt_pkg::PAYLOAD_BYTES-1:0] change;
    logic [cidt_pkg::DATA_W-1:0]        bit_mask;
    logic                               len_diff;
    logic                               any;

    always_comb begin
        for (int i = 0; i < cidt_pkg::PAYLOAD_BYTES; i++) begin
            // dlc above eight covers all bytes
            in_len[i] = (i_dlc > cidt_pkg::DLC_W'(i));
            // byte beyond the stored length counts as newly present
            change[i] = in_len[i] &&
                        ((i_row.length <= cidt_pkg::DLC_W'(i)) ||
                         (i_data[8*i +: 8] != i_row.bytes[8*i +: 8]));
            bit_mask[8*i +: 8] = {8{in_len[i]}};
        end
    end

    assign len_diff = (i_dlc != i_row.length);
    assign any      = len_diff || (change != '0);

    always_comb begin
        o_row = i_row;
        if (i_insert) begin
            o_row.length  = i_dlc;
            o_row.bytes   = i_data & bit_mask;
            o_row.flags   = '0;
            o_row.flags[cidt_pkg::FLAG_NEW_BIT] = 1'b1;
            o_row.last_us = i_rel;
            o_row.count   = cidt_pkg::COUNT_W'(1);
        end else begin
            o_row.flags[cidt_pkg::FLAG_MASK_LSB +: cidt_pkg::PAYLOAD_BYTES] = change;
            o_row.flags[cidt_pkg::FLAG_LEN_BIT] = len_diff;
            if (any) begin
                o_row.flags[cidt_pkg::FLAG_NEW_BIT] = 1'b0;
                o_row.length  = i_dlc;
                o_row.bytes   = (i_row.bytes & ~bit_mask) | (i_data & bit_mask);
                o_row.last_us = i_rel;
                if (i_row.count != '1) begin
                    o_row.count = i_row.count + cidt_pkg::COUNT_W'(1);
                end
            end
        end
    end

    always_comb begin
        o_result.first_seen       = o_row.flags[cidt_pkg::FLAG_NEW_BIT];
        o_result.length_changed   = o_row.flags[cidt_pkg::FLAG_LEN_BIT];
        o_result.byte_change_mask =
            o_row.flags[cidt_pkg::FLAG_MASK_LSB +: cidt_pkg::PAYLOAD_BYTES];
        o_result.row_updated      = i_insert || any;
        o_result.update_total     = o_row.count;
        o_result.last_change_us   = o_row.last_us;
        o_result.table_full       = 1'b0;
    end

endmodule

// ----- rtl/core/can_id_change_tracker.sv -----
// top level of the can identifier change tracker
// depends on cidt_pkg, cidt_if, cidt_ram, cidt_lane, cidt_merge, cidt_row_update
//
// Takes one received CAN frame at a time and keeps one row per identifier. Rows are
// filled in order and never freed, so a fill count marks the used rows and no clearing
// pass is needed after reset. For each frame the key search reads the key memories of
// eight compare lanes, eight rows per cycle, and the drain, decide, load and write
// states then resolve the hit, read the row memory, compute the update and write it
// back. A finished result sits in an output register and does not hold off the next
// frame until it is ready to be written there.
module can_id_change_tracker #(
    parameter int TABLE_ROWS = cidt_pkg::TABLE_ROWS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [cidt_pkg::TIME_W-1:0]   i_cfg_wr_data,
    cidt_frame_if.sink                    i_frame,
    cidt_result_if.source                 o_result
);

    localparam int LANES  = cidt_pkg::LANES;
    localparam int LANE_W = cidt_pkg::LANE_W;
    localparam int GROUPS = (TABLE_ROWS + LANES - 1) / LANES;
    localparam int GRP_W  = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int ROW_W  = GRP_W + LANE_W;
    localparam int FILL_W = $clog2(TABLE_ROWS + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_LOAD   = 3'd4;
    localparam logic [2:0] ST_WRITE  = 3'd5;

    logic [2:0]                    r_state, n_state;
    logic [GRP_W-1:0]              r_grp;
    logic                          r_cmp_valid;
    logic [GRP_W-1:0]              r_cmp_grp;
    logic                          r_found;
    logic [ROW_W-1:0]              r_hit_row;
    logic [FILL_W-1:0]             r_fill;
    logic [cidt_pkg::TIME_W-1:0]   r_start;
    logic                          r_insert;
    logic                          r_full;
    logic [ROW_W-1:0]              r_row_addr;
    logic [cidt_pkg::KEY_W-1:0]    r_key;
    logic [cidt_pkg::DLC_W-1:0]    r_dlc;
    logic [cidt_pkg::DATA_W-1:0]   r_data;
    logic [cidt_pkg::TIME_W-1:0]   r_rel;
    logic [cidt_pkg::TIME_W-1:0]   n_rel;
    cidt_pkg::t_row                r_upd_row;
    cidt_pkg::t_result             r_upd_res;
    logic                          r_out_valid;
    cidt_pkg::t_result             r_out;

    logic                          in_xact;
    logic                          wr_go;
    logic                          key_we;
    logic [LANES-1:0]              lane_hits;
    logic                          merge_hit;
    logic [LANE_W-1:0]             merge_lane;
    logic [cidt_pkg::ROW_DATA_W-1:0] row_rd_data;
    cidt_pkg::t_row                upd_row;
    cidt_pkg::t_result             upd_res;
    cidt_pkg::t_result             full_res;

    assign i_frame.ready = (r_state == ST_IDLE);
    assign in_xact       = i_frame.valid && i_frame.ready;
    assign wr_go         = (r_state == ST_WRITE) && (!r_out_valid || o_result.ready);
    assign key_we        = wr_go && r_insert;

    // frame time relative to session start, clamped at zero
    assign n_rel = (i_frame.host_time_us >= r_start) ?
                   (i_frame.host_time_us - r_start) : '0;

    // dropped frame reports only the full flag
    always_comb begin
        full_res            = '0;
        full_res.table_full = 1'b1;
    end

    // key compare lanes
    for (genvar l = 0; l < LANES; l++) begin : g_lane
        cidt_lane #(
            .GROUPS   (GROUPS),
            .GRP_W    (GRP_W),
            .FILL_W   (FILL_W),
            .LANE_IDX (l)
        ) u_lane (
            .i_clk     (i_clk),
            .i_wr_en   (key_we && (r_row_addr[LANE_W-1:0] == LANE_W'(l))),
            .i_wr_grp  (r_row_addr[ROW_W-1:LANE_W]),
            .i_wr_key  (r_key),
            .i_rd_grp  (r_grp),
            .i_cmp_grp (r_cmp_grp),
            .i_key     (r_key),
            .i_fill    (r_fill),
            .o_hit     (lane_hits[l])
        );
    end

    cidt_merge u_merge (
        .i_hits (lane_hits),
        .o_hit  (merge_hit),
        .o_lane (merge_lane)
    );

    cidt_ram #(
        .WIDTH (cidt_pkg::ROW_DATA_W),
        .DEPTH (GROUPS * LANES)
    ) u_row_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_go && !r_full),
        .i_wr_addr (r_row_addr),
        .i_wr_data (r_upd_row),
        .i_rd_addr (r_hit_row),
        .o_rd_data (row_rd_data)
    );

    cidt_row_update u_row_update (
        .i_insert (r_insert),
        .i_row    (cidt_pkg::t_row'(row_rd_data)),
        .i_dlc    (r_dlc),
        .i_data   (r_data),
        .i_rel    (r_rel),
        .o_row    (upd_row),
        .o_result (upd_res)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_xact) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_grp == GRP_W'(GROUPS - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN:  n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_LOAD;
            ST_LOAD:   n_state = ST_WRITE;
            ST_WRITE: begin
                if (wr_go) begin
                    n_state = ST_IDLE;
                end
            end
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cmp_valid <= 1'b0;
            r_found     <= 1'b0;
            r_fill      <= '0;
            r_start     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_valid <= (r_state == ST_SCAN);
            if (i_cfg_wr_en) begin
                r_start <= i_cfg_wr_data;
            end
            if (in_xact) begin
                r_found <= 1'b0;
            end else if (r_cmp_valid && merge_hit && !r_found) begin
                r_found <= 1'b1;
            end
            if (key_we) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            if (wr_go) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xact) begin
            r_key  <= i_frame.can_id;
            r_dlc  <= i_frame.length_code;
            r_data <= i_frame.payload;
            r_rel  <= n_rel;
            r_grp  <= '0;
        end else if (r_state == ST_SCAN) begin
            r_grp <= r_grp + GRP_W'(1);
        end
        r_cmp_grp <= r_grp;
        // groups are scanned in ascending order, so the first hit is the lowest row
        if (r_cmp_valid && merge_hit && !r_found) begin
            r_hit_row <= {r_cmp_grp, merge_lane};
        end
        if (r_state == ST_DECIDE) begin
            r_insert   <= !r_found && (r_fill < FILL_W'(TABLE_ROWS));
            r_full     <= !r_found && (r_fill >= FILL_W'(TABLE_ROWS));
            r_row_addr <= r_found ? r_hit_row : ROW_W'(r_fill);
        end
        if (r_state == ST_LOAD) begin
            r_upd_row <= upd_row;
            r_upd_res <= r_full ? full_res : upd_res;
        end
        if (wr_go) begin
            r_out <= r_upd_res;
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.first_seen       = r_out.first_seen;
    assign o_result.length_changed   = r_out.length_changed;
    assign o_result.byte_change_mask = r_out.byte_change_mask;
    assign o_result.row_updated      = r_out.row_updated;
    assign o_result.update_total     = r_out.update_total;
    assign o_result.last_change_us   = r_out.last_change_us;
    assign o_result.table_full       = r_out.table_full;

endmodule

// ----- rtl/core/cidt_checker.sv -----
// port-level checks for the identifier change tracker, bound to the top level
// depends on cidt_pkg and can_id_change_tracker
module cidt_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic                               i_first_seen,
    input logic                               i_length_changed,
    input logic [cidt_pkg::PAYLOAD_BYTES-1:0] i_byte_change_mask,
    input logic                               i_row_updated,
    input logic [cidt_pkg::COUNT_W-1:0]       i_update_total,
    input logic                               i_table_full
);

    // a dropped frame reports nothing but the full flag
    a_full_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_table_full |->
            !i_first_seen && !i_row_updated && !i_length_changed &&
            (i_byte_change_mask == '0) && (i_update_total == '0))
        else $error("table full result carries row data");

    // a row still marked new has never changed since its insert
    a_new_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_first_seen |->
            (i_update_total == cidt_pkg::COUNT_W'(1)) && !i_length_changed &&
            (i_byte_change_mask == '0))
        else $error("new row shows a change or a count other than one");

    // an unchanged frame on a known row shows no change
    a_no_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_row_updated && !i_table_full |->
            !i_length_changed && (i_byte_change_mask == '0))
        else $error("change flags set without an update");

    // one frame at a time: busy right after a transaction
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("frame accepted while previous one still in work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped before transaction");

endmodule

bind can_id_change_tracker cidt_checker u_cidt_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_frame.valid),
    .i_in_ready         (i_frame.ready),
    .i_out_valid        (o_result.valid),
    .i_out_ready        (o_result.ready),
    .i_first_seen       (o_result.first_seen),
    .i_length_changed   (o_result.length_changed),
    .i_byte_change_mask (o_result.byte_change_mask),
    .i_row_updated      (o_result.row_updated),
    .i_update_total     (o_result.update_total),
    .i_table_full       (o_result.table_full)
);
